>>> src/sbot_pkg.sv
package sbot_pkg;

	localparam int MAX_BARRIERS_DEF = 1024;

	localparam int OP_W = 2;
	localparam int COORD_W = 16;
	localparam int PROD_W = 2 * COORD_W;
	localparam int ENTRY_W = 4 * COORD_W;

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic write;
		logic start;
		logic rd_en;
		logic load_out;
		logic resp_status;
	} sbot_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic last;
		logic busy;
	} sbot_sts_t;

endpackage

>>> src/sbot_ctrl.sv
module sbot_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sbot_pkg::OP_W-1:0]     operation,
	output logic                          out_valid,
	input  logic                          out_stall,
	input  sbot_pkg::sbot_sts_t           sts,
	output sbot_pkg::sbot_cmd_t           cmd
);
	import sbot_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_RESP = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       resp_status_q;
	logic       resp_status_d;
	logic       out_valid_q;
	logic       accept;
	logic       slot_free;

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		resp_status_d = resp_status_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (operation)
						OP_CLEAR: begin
							cmd.clear = 1'b1;
						end
						OP_APPEND: begin
							if (sts.full) begin
								resp_status_d = 1'b1;
								state_d = S_RESP;
							end else begin
								cmd.write = 1'b1;
							end
						end
						OP_QUERY: begin
							cmd.start = 1'b1;
							resp_status_d = 1'b0;
							state_d = sts.empty ? S_RESP : S_SCAN;
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				cmd.rd_en = 1'b1;
				if (sts.last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!sts.busy) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				cmd.resp_status = resp_status_q;
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			resp_status_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			resp_status_q <= resp_status_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> src/sbot_dp.sv
module sbot_dp #(
	parameter int MaxBarriers = sbot_pkg::MAX_BARRIERS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic signed [sbot_pkg::COORD_W-1:0] x_start,
	input  logic signed [sbot_pkg::COORD_W-1:0] y_start,
	input  logic signed [sbot_pkg::COORD_W-1:0] x_end,
	input  logic signed [sbot_pkg::COORD_W-1:0] y_end,
	input  sbot_pkg::sbot_cmd_t              cmd,
	output sbot_pkg::sbot_sts_t              sts,
	output logic                             hit,
	output logic                             status
);
	import sbot_pkg::*;

	localparam int AW = (MaxBarriers > 1) ? $clog2(MaxBarriers) : 1;
	localparam int CW = AW + 1;

	logic [ENTRY_W-1:0] mem [MaxBarriers];

	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q;

	// query endpoints and the shared b-a direction
	coord_t ax_q, ay_q, bx_q, by_q, bax_q, bay_q;

	logic               v_s1, v_s2, v_s3;
	logic [ENTRY_W-1:0] rd_s1;
	coord_t             cx, cy, dx, dy;
	coord_t             bcx_s2, bcy_s2, bdx_s2, bdy_s2;
	coord_t             dcx_s2, dcy_s2, dax_s2, day_s2, dbx_s2, dby_s2;
	prod_t              p1l_s3, p1r_s3, p2l_s3, p2r_s3;
	prod_t              p3l_s3, p3r_s3, p4l_s3, p4r_s3;
	logic [1:0]         o1, o2, o3, o4;
	logic               seg_cross;
	logic               hit_q;
	logic               out_hit_q;
	logic               out_status_q;

	assign sts.full = (count_q == CW'(MaxBarriers));
	assign sts.empty = (count_q == '0);
	assign sts.last = ({1'b0, idx_q} == (count_q - CW'(1)));
	assign sts.busy = v_s1 || v_s2 || v_s3;

	assign hit = out_hit_q;
	assign status = out_status_q;

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			mem[count_q[AW-1:0]] <= {y_end, x_end, y_start, x_start};
		end
		if (cmd.rd_en) begin
			rd_s1 <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.write) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.start) begin
				idx_q <= '0;
			end else if (cmd.rd_en) begin
				idx_q <= idx_q + AW'(1);
			end
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.start) begin
				hit_q <= 1'b0;
			end else if (v_s3 && seg_cross) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			ax_q <= x_start;
			ay_q <= y_start;
			bx_q <= x_end;
			by_q <= y_end;
			bax_q <= x_end - x_start;
			bay_q <= y_end - y_start;
		end
		if (cmd.load_out) begin
			out_hit_q <= cmd.resp_status ? 1'b0 : hit_q;
			out_status_q <= cmd.resp_status;
		end
	end

	assign cx = rd_s1[COORD_W-1:0];
	assign cy = rd_s1[2*COORD_W-1:COORD_W];
	assign dx = rd_s1[3*COORD_W-1:2*COORD_W];
	assign dy = rd_s1[4*COORD_W-1:3*COORD_W];

	// coordinate differences wrap to 16 bits
	always_ff @(posedge clk) begin
		bcx_s2 <= bx_q - cx;
		bcy_s2 <= by_q - cy;
		bdx_s2 <= bx_q - dx;
		bdy_s2 <= by_q - dy;
		dcx_s2 <= dx - cx;
		dcy_s2 <= dy - cy;
		dax_s2 <= dx - ax_q;
		day_s2 <= dy - ay_q;
		dbx_s2 <= dx - bx_q;
		dby_s2 <= dy - by_q;
	end

	// eight 16x16 lanes, the two sides of each cross product
	always_ff @(posedge clk) begin
		p1l_s3 <= bax_q * bcy_s2;
		p1r_s3 <= bay_q * bcx_s2;
		p2l_s3 <= bax_q * bdy_s2;
		p2r_s3 <= bay_q * bdx_s2;
		p3l_s3 <= dcx_s2 * day_s2;
		p3r_s3 <= dcy_s2 * dax_s2;
		p4l_s3 <= dcx_s2 * dby_s2;
		p4r_s3 <= dcy_s2 * dbx_s2;
	end

	// sign as {greater, less}
	assign o1 = {p1l_s3 > p1r_s3, p1l_s3 < p1r_s3};
	assign o2 = {p2l_s3 > p2r_s3, p2l_s3 < p2r_s3};
	assign o3 = {p3l_s3 > p3r_s3, p3l_s3 < p3r_s3};
	assign o4 = {p4l_s3 > p4r_s3, p4l_s3 < p4r_s3};
	assign seg_cross = (o1 != o2) && (o3 != o4);

endmodule

>>> src/segment_barrier_occlusion_test_top.sv
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | operation, x_start, y_start, x_end, y_end
// out     | output    | out_valid/out_stall| hit, status
//
// clear and append complete when taken and leave the input open; a query scans the
// barrier memory through its read port, one entry per cycle, drains the pipeline
// and loads the output register once it is free; a full append or an empty query skips the scan
// reset clears the barrier count but not the barrier memory
// a pending result in the output register holds while out_stall is high
// in_stall is high from a query or a dropped append until its result is loaded
module segment_barrier_occlusion_test_top #(
	parameter int MAX_BARRIERS = sbot_pkg::MAX_BARRIERS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [sbot_pkg::OP_W-1:0]           operation,
	input  logic signed [sbot_pkg::COORD_W-1:0] x_start,
	input  logic signed [sbot_pkg::COORD_W-1:0] y_start,
	input  logic signed [sbot_pkg::COORD_W-1:0] x_end,
	input  logic signed [sbot_pkg::COORD_W-1:0] y_end,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                hit,
	output logic                                status
);
	import sbot_pkg::*;

	sbot_cmd_t cmd;
	sbot_sts_t sts;

	sbot_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sbot_dp #(
		.MaxBarriers (MAX_BARRIERS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.x_start (x_start),
		.y_start (y_start),
		.x_end   (x_end),
		.y_end   (y_end),
		.cmd     (cmd),
		.sts     (sts),
		.hit     (hit),
		.status  (status)
	);

endmodule

>>> src/sbot_chk.sv
module sbot_chk (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [sbot_pkg::OP_W-1:0] operation,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic                      hit,
	input  logic                      status
);
	import sbot_pkg::*;

	// a dropped append never reports a hit
	a_status_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && status))
		else $error("dropped append reported a hit");

	// a query transaction blocks the input right after it is taken
	a_query_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && operation == OP_QUERY) |=> in_stall)
		else $error("input open right after a query");

	// clear leaves the input open right after it is taken
	a_clear_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && operation == OP_CLEAR) |=> !in_stall)
		else $error("input stalled after clear");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(hit) && $stable(status)))
		else $error("stalled result changed");

endmodule

bind segment_barrier_occlusion_test_top sbot_chk u_sbot_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.operation (operation),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.hit       (hit),
	.status    (status)
);

>>> tb/sv/testbench.sv
module testbench;
	import sbot_pkg::*;

	localparam int TABLE_DEPTH = MAX_BARRIERS_DEF;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int RANDOM_ITEMS = 580;
	localparam int DRAIN_CYCLES = TABLE_DEPTH + 80;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic STATUS_ANSWERED = 1'b0;
	localparam logic STATUS_DROPPED = 1'b1;

	typedef struct packed {
		logic [OP_W-1:0] op;
		coord_t xs;
		coord_t ys;
		coord_t xe;
		coord_t ye;
	} request_t;

	typedef struct packed {
		coord_t xs;
		coord_t ys;
		coord_t xe;
		coord_t ye;
	} barrier_t;

	typedef struct packed {
		logic hit;
		logic status;
	} verdict_t;

	typedef enum {NEAR_ORIGIN, MID_RANGE, FULL_RANGE, EDGE_VALUES} spread_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [OP_W-1:0] operation;
	coord_t x_start;
	coord_t y_start;
	coord_t x_end;
	coord_t y_end;
	logic out_valid;
	logic out_stall;
	logic hit;
	logic status;

	request_t drive_req;
	request_t request_backlog[$];
	verdict_t pending_verdicts[$];
	verdict_t seen_want;
	barrier_t barrier_copy[TABLE_DEPTH];
	int barrier_total;
	int requests_total;
	int requests_taken;
	int mismatch_count;
	int cycle_count;
	int send_gap;
	int calm_left;
	int hold_left;
	int quiet_left;
	logic in_took;
	int session_items;
	int n;

	segment_barrier_occlusion_test_top #(
		.MAX_BARRIERS(TABLE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.x_start(x_start),
		.y_start(y_start),
		.x_end(x_end),
		.y_end(y_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.status(status)
	);

	assign operation = drive_req.op;
	assign x_start = drive_req.xs;
	assign y_start = drive_req.ys;
	assign x_end = drive_req.xe;
	assign y_end = drive_req.ye;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// sign of ux*vy - uy*vx from an exact comparison of the two products
	function automatic int orientation(coord_t ux, coord_t uy, coord_t vx, coord_t vy);
		int lhs;
		int rhs;
		lhs = int'(ux) * int'(vy);
		rhs = int'(uy) * int'(vx);
		if (lhs > rhs)
			return 1;
		if (lhs < rhs)
			return -1;
		return 0;
	endfunction

	function automatic logic segments_meet(coord_t ax, coord_t ay, coord_t bx, coord_t by,
			barrier_t w);
		coord_t bax;
		coord_t bay;
		coord_t dcx;
		coord_t dcy;
		int o1;
		int o2;
		int o3;
		int o4;
		// differences wrap to 16 bits
		bax = bx - ax;
		bay = by - ay;
		dcx = w.xe - w.xs;
		dcy = w.ye - w.ys;
		o1 = orientation(bax, bay, coord_t'(bx - w.xs), coord_t'(by - w.ys));
		o2 = orientation(bax, bay, coord_t'(bx - w.xe), coord_t'(by - w.ye));
		o3 = orientation(dcx, dcy, coord_t'(w.xe - ax), coord_t'(w.ye - ay));
		o4 = orientation(dcx, dcy, coord_t'(w.xe - bx), coord_t'(w.ye - by));
		return (o1 != o2) && (o3 != o4);
	endfunction

	function automatic void apply_request(request_t r);
		verdict_t v;
		case (r.op)
			OP_CLEAR: barrier_total = 0;
			OP_APPEND: begin
				if (barrier_total >= TABLE_DEPTH) begin
					v.hit = 1'b0;
					v.status = STATUS_DROPPED;
					pending_verdicts.push_back(v);
				end else begin
					barrier_copy[barrier_total] = '{r.xs, r.ys, r.xe, r.ye};
					barrier_total++;
				end
			end
			OP_QUERY: begin
				v.hit = 1'b0;
				v.status = STATUS_ANSWERED;
				for (int i = 0; i < barrier_total; i++) begin
					if (segments_meet(r.xs, r.ys, r.xe, r.ye, barrier_copy[i])) begin
						v.hit = 1'b1;
						break;
					end
				end
				pending_verdicts.push_back(v);
			end
			default: ;
		endcase
	endfunction

	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic spread_t pick_spread();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return NEAR_ORIGIN;
		if (r < 55)
			return MID_RANGE;
		if (r < 90)
			return FULL_RANGE;
		return EDGE_VALUES;
	endfunction

	function automatic coord_t pick_coord(spread_t s);
		case (s)
			NEAR_ORIGIN: return coord_t'(int'($urandom_range(0, 12)) - 6);
			MID_RANGE: return coord_t'(int'($urandom_range(0, 600)) - 300);
			FULL_RANGE: return coord_t'($urandom());
			default: begin
				case ($urandom_range(0, 5))
					0: return 16'sh8000;
					1: return 16'sh7fff;
					2: return 16'sh8001;
					3: return 16'sh0000;
					4: return 16'shffff;
					default: return 16'sh0001;
				endcase
			end
		endcase
	endfunction

	task automatic queue_item(logic [OP_W-1:0] op, coord_t xs, coord_t ys, coord_t xe,
			coord_t ye);
		request_backlog.push_back('{op, xs, ys, xe, ye});
	endtask

	// mostly one spread per segment so that short segments actually meet
	task automatic queue_random(logic [OP_W-1:0] op);
		spread_t s;
		coord_t c[4];
		s = pick_spread();
		for (int i = 0; i < 4; i++)
			c[i] = pick_coord(($urandom_range(0, 9) == 0) ? pick_spread() : s);
		queue_item(op, c[0], c[1], c[2], c[3]);
	endtask

	// input side: predict each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_took <= 1'b0;
		end else begin
			in_took <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				apply_request(drive_req);
				requests_taken++;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_took) begin
				// stalled, hold the payload
			end else if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (request_backlog.size() > 0) begin
				drive_req <= request_backlog.pop_front();
				in_valid <= 1'b1;
				if (calm_left > 0) begin
					calm_left <= calm_left - 1;
					send_gap <= 0;
				end else begin
					send_gap <= pick_idle();
					if ($urandom_range(0, 49) == 0)
						calm_left <= $urandom_range(20, 60);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (quiet_left > 0) begin
				out_stall <= 1'b0;
				quiet_left <= quiet_left - 1;
			end else begin
				out_stall <= 1'b0;
				hold_left <= pick_idle();
				quiet_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(30, 100)
					: $urandom_range(0, 4);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				$error("unexpected result: hit %0b status %0b", hit, status);
				mismatch_count++;
			end else begin
				seen_want = pending_verdicts.pop_front();
				if (hit !== seen_want.hit) begin
					$error("hit: expected %0b, actual %0b", seen_want.hit, hit);
					mismatch_count++;
				end
				if (status !== seen_want.status) begin
					$error("status: expected %0b, actual %0b", seen_want.status, status);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		drive_req = '0;
		barrier_total = 0;
		requests_taken = 0;
		mismatch_count = 0;
		cycle_count = 0;
		send_gap = 0;
		calm_left = 0;
		hold_left = 0;
		quiet_left = 0;

		// directed: empty table, unused code, extremes, crossing and touching cases
		queue_item(OP_QUERY, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
		queue_item(OP_UNUSED, 16'sh7fff, 16'sh8000, 16'shffff, 16'sh0000);
		queue_item(OP_APPEND, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
		queue_item(OP_QUERY, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
		queue_item(OP_CLEAR, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		queue_item(OP_APPEND, 0, 0, 10, 0);
		queue_item(OP_QUERY, 5, -5, 5, 5);
		queue_item(OP_QUERY, 10, 0, 20, 0);
		queue_item(OP_QUERY, 11, 0, 20, 0);
		queue_item(OP_QUERY, 0, 1, 10, 1);
		queue_item(OP_QUERY, 5, 0, 5, 7);
		queue_item(OP_QUERY, -3, 0, 4, 0);
		queue_item(OP_CLEAR, 0, 0, 0, 0);
		queue_item(OP_QUERY, 5, -5, 5, 5);
		queue_item(OP_APPEND, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
		queue_item(OP_APPEND, -1, -1, 1, 1);
		queue_item(OP_APPEND, 3, 3, 3, 3);
		queue_item(OP_QUERY, 0, 6, 6, 0);
		queue_item(OP_QUERY, 100, 100, 200, 100);
		queue_item(OP_QUERY, 16'sh8000, 0, 16'sh7fff, 0);
		queue_item(OP_UNUSED, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
		queue_item(OP_QUERY, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
		queue_item(OP_CLEAR, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);

		// random: build a small table, then query it, with some noise
		session_items = 0;
		while (session_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) != 0) begin
				queue_random(OP_CLEAR);
				session_items++;
			end
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(0, 10);
			for (int i = 0; i < n; i++)
				queue_random(OP_APPEND);
			session_items += n;
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 19))
					0: queue_random(OP_UNUSED);
					1, 2, 3: begin
						queue_random(OP_APPEND);
						session_items++;
					end
					default: begin
						queue_random(OP_QUERY);
						session_items++;
					end
				endcase
			end
		end

		// fill the table to the top, then overflow it
		queue_random(OP_CLEAR);
		for (int i = 0; i < TABLE_DEPTH; i++)
			queue_random(OP_APPEND);
		for (int i = 0; i < 3; i++)
			queue_random(OP_QUERY);
		for (int i = 0; i < 3; i++)
			queue_random(OP_APPEND);
		queue_random(OP_QUERY);
		queue_random(OP_UNUSED);
		queue_random(OP_APPEND);
		queue_random(OP_CLEAR);
		queue_random(OP_QUERY);
		queue_random(OP_APPEND);
		queue_random(OP_QUERY);

		requests_total = request_backlog.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (requests_taken != requests_total)
			@(posedge clk);
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_verdicts.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
